### rtl/afr_pkg.sv
// Package for the addressed frame receiver: codes, result type and constants.
`default_nettype none

package afr_pkg;

  localparam int unsigned ByteW         = 8;
  localparam int unsigned KindW         = 2;
  localparam int unsigned CfgIdxW       = 1;
  localparam int unsigned MaxDataLenDef = 128;
  localparam logic [ByteW-1:0] OwnAddrRst   = 8'hFF;
  localparam logic [ByteW-1:0] StartByteRst = 8'hEF;

  typedef enum logic [2:0] {
    PH_HUNT  = 3'd0,
    PH_ADDR  = 3'd1,
    PH_LEN   = 3'd2,
    PH_DATA  = 3'd3,
    PH_CHECK = 3'd4
  } phase_e;

  typedef enum logic [KindW-1:0] {
    KIND_DATA = 2'd0,
    KIND_GOOD = 2'd1,
    KIND_BAD  = 2'd2
  } kind_e;

  typedef enum logic [CfgIdxW-1:0] {
    REG_OWN_ADDRESS = 1'd0,
    REG_START_BYTE  = 1'd1
  } cfg_reg_e;

  typedef struct packed {
    kind_e            kind;
    logic [ByteW-1:0] payload_byte;
    logic [ByteW-1:0] byte_position;
  } frame_result_t;

endpackage

`default_nettype wire

### rtl/afr_parser.sv
// Frame parser: phase state machine, length/count tracking and checksum.
`default_nettype none

module afr_parser
  import afr_pkg::*;
#(
  parameter int unsigned MAX_DATA_LEN = MaxDataLenDef
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             advance_i,
  input  wire logic [ByteW-1:0] rx_byte_i,
  input  wire logic [ByteW-1:0] own_address_i,
  input  wire logic [ByteW-1:0] start_byte_i,
  output logic                  res_valid_o,
  output frame_result_t         res_o
);

  localparam logic [ByteW-1:0] MaxLen = ByteW'(MAX_DATA_LEN);

  phase_e           phase_q, phase_d;
  logic [ByteW-1:0] frame_length_q, frame_length_d;
  logic [ByteW-1:0] data_count_q, data_count_d;
  logic [ByteW-1:0] running_xor_q, running_xor_d;
  logic [ByteW-1:0] count_inc;

  assign count_inc = data_count_q + 1'b1;

  always_comb begin
    phase_d        = phase_q;
    frame_length_d = frame_length_q;
    data_count_d   = data_count_q;
    running_xor_d  = running_xor_q;
    res_valid_o    = 1'b0;
    res_o.kind          = KIND_DATA;
    res_o.payload_byte  = rx_byte_i;
    res_o.byte_position = data_count_q;
    case (phase_q)
      PH_ADDR: begin
        phase_d = (rx_byte_i == own_address_i) ? PH_LEN : PH_HUNT;
      end
      PH_LEN: begin
        if (rx_byte_i > MaxLen) begin
          phase_d = PH_HUNT;
        end else begin
          frame_length_d = rx_byte_i;
          data_count_d   = '0;
          running_xor_d  = rx_byte_i;
          phase_d        = (rx_byte_i == '0) ? PH_CHECK : PH_DATA;
        end
      end
      PH_DATA: begin
        res_valid_o   = 1'b1;
        running_xor_d = running_xor_q ^ rx_byte_i;
        data_count_d  = count_inc;
        if (count_inc == frame_length_q) begin
          phase_d = PH_CHECK;
        end
      end
      PH_CHECK: begin
        res_valid_o         = 1'b1;
        res_o.kind          = (rx_byte_i == running_xor_q) ? KIND_GOOD : KIND_BAD;
        res_o.byte_position = frame_length_q;
        phase_d             = PH_HUNT;
      end
      default: begin
        // unused codes behave as hunting
        phase_d = (rx_byte_i == start_byte_i) ? PH_ADDR : PH_HUNT;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q        <= PH_HUNT;
      frame_length_q <= '0;
      data_count_q   <= '0;
      running_xor_q  <= '0;
    end else if (advance_i) begin
      phase_q        <= phase_d;
      frame_length_q <= frame_length_d;
      data_count_q   <= data_count_d;
      running_xor_q  <= running_xor_d;
    end
  end

endmodule

`default_nettype wire

### rtl/afr_out_skid.sv
// Result register with skid stage, decoupling input ready from output ready.
`default_nettype none

module afr_out_skid
  import afr_pkg::*;
(
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          push_i,
  input  wire frame_result_t push_data_i,
  output logic               space_o,
  output logic               out_valid_o,
  input  wire logic          out_ready_i,
  output frame_result_t      out_data_o
);

  logic          out_valid_q, out_valid_d;
  logic          skid_valid_q, skid_valid_d;
  frame_result_t out_data_q, out_data_d;
  frame_result_t skid_data_q, skid_data_d;
  logic          pop;

  assign pop         = out_valid_q && out_ready_i;
  assign space_o     = !skid_valid_q;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

  always_comb begin
    out_valid_d  = out_valid_q;
    skid_valid_d = skid_valid_q;
    out_data_d   = out_data_q;
    skid_data_d  = skid_data_q;
    if (skid_valid_q) begin
      // no push possible while the skid holds a request
      if (pop) begin
        out_data_d   = skid_data_q;
        skid_valid_d = 1'b0;
      end
    end else if (push_i) begin
      if (!out_valid_q || pop) begin
        out_data_d  = push_data_i;
        out_valid_d = 1'b1;
      end else begin
        skid_data_d  = push_data_i;
        skid_valid_d = 1'b1;
      end
    end else if (pop) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else begin
      out_valid_q  <= out_valid_d;
      skid_valid_q <= skid_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_data_q  <= out_data_d;
    skid_data_q <= skid_data_d;
  end

endmodule

`default_nettype wire

### rtl/addressed_frame_receiver.sv
// Addressed frame receiver: top level with configuration registers.
//
// Bytes enter on the rx channel (in_valid_i / in_ready_o / rx_byte_i) and
// are parsed as start, address, length, data..., checksum. Each data byte
// comes out as a request of kind data with its index; the checksum byte
// gives one request of kind good or bad with the frame length. Other bytes
// give no output request.
// Throughput is one byte per cycle while in_ready_o is high; the parser
// state machine decides each byte combinationally. An output request is
// registered and shows on out_valid_o once it is in the output register.
// A two-entry result stage (output register plus skid) lets a byte be taken
// while a result waits; in_ready_o drops only once both entries are full, so
// a stalled receiver holds off the input after at most two pending results.
// Reset clears the parser to hunting, empties the result stage and loads
// own_address 0xFF and start_byte 0xEF. Configuration writes via cfg_we_i
// apply from the next byte.
`default_nettype none

module addressed_frame_receiver
  import afr_pkg::*;
#(
  parameter int unsigned MAX_DATA_LEN = MaxDataLenDef
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               cfg_we_i,
  input  wire logic [CfgIdxW-1:0] cfg_idx_i,
  input  wire logic [ByteW-1:0]   cfg_data_i,
  input  wire logic               in_valid_i,
  output logic                    in_ready_o,
  input  wire logic [ByteW-1:0]   rx_byte_i,
  output logic                    out_valid_o,
  input  wire logic               out_ready_i,
  output logic [KindW-1:0]        kind_o,
  output logic [ByteW-1:0]        payload_byte_o,
  output logic [ByteW-1:0]        byte_position_o
);

  logic [ByteW-1:0] own_address_q;
  logic [ByteW-1:0] start_byte_q;
  logic             advance;
  logic             res_valid;
  frame_result_t    res;
  frame_result_t    out_data;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      own_address_q <= OwnAddrRst;
      start_byte_q  <= StartByteRst;
    end else if (cfg_we_i) begin
      case (cfg_reg_e'(cfg_idx_i))
        REG_OWN_ADDRESS: own_address_q <= cfg_data_i;
        REG_START_BYTE:  start_byte_q  <= cfg_data_i;
        default: ;
      endcase
    end
  end

  assign advance = in_valid_i && in_ready_o;

  afr_parser #(
    .MAX_DATA_LEN(MAX_DATA_LEN)
  ) u_parser (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .advance_i    (advance),
    .rx_byte_i    (rx_byte_i),
    .own_address_i(own_address_q),
    .start_byte_i (start_byte_q),
    .res_valid_o  (res_valid),
    .res_o        (res)
  );

  afr_out_skid u_out (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (advance && res_valid),
    .push_data_i(res),
    .space_o    (in_ready_o),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_data_o (out_data)
  );

  assign kind_o          = out_data.kind;
  assign payload_byte_o  = out_data.payload_byte;
  assign byte_position_o = out_data.byte_position;

endmodule

`default_nettype wire
